// ===== rtl/core/block_io_statistics_counter_macros.svh =====
// ----------------------------------------------------------------------------
// Block I/O statistics counter - assertion macros
// Concurrent assertion wrappers, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef BLOCK_IO_STATISTICS_COUNTER_MACROS_SVH
`define BLOCK_IO_STATISTICS_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

`define BIO_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define BIO_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define BIO_ASSERT(label, clk, rst_n, prop, msg)

`define BIO_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/core/bio_pkg.sv =====
// ----------------------------------------------------------------------------
// Block I/O statistics counter package
// Event codes, counter indices and the registered request format.
// ----------------------------------------------------------------------------
package bio_pkg;

    localparam int CNT_WIDTH_DEFAULT = 64;
    localparam int SECTOR_W          = 64;
    localparam int COUNT_W           = 32;
    localparam int NUM_COUNTERS      = 13;
    localparam int CNT_IDX_W         = 4;

    typedef enum logic [1:0] {
        REQ_ISSUE    = 2'd0,
        REQ_COMPLETE = 2'd1,
        REQ_READ     = 2'd2,
        REQ_CLEAR    = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        OUTCOME_SUCCESS = 2'd0,
        OUTCOME_RETRY   = 2'd1,
        OUTCOME_ERROR   = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        DIR_READ  = 2'd0,
        DIR_WRITE = 2'd1,
        DIR_NONE  = 2'd2
    } dir_t;

    localparam logic [CNT_IDX_W-1:0] IDX_RD_ISSUE  = 4'd0;
    localparam logic [CNT_IDX_W-1:0] IDX_WR_ISSUE  = 4'd4;
    localparam logic [CNT_IDX_W-1:0] IDX_CPL_RD    = 4'd8;
    localparam logic [CNT_IDX_W-1:0] IDX_CPL_WR    = 4'd10;
    localparam logic [CNT_IDX_W-1:0] IDX_FAILED    = 4'd12;

    localparam logic [CNT_IDX_W-1:0] OFS_SECTORS   = 4'd0;
    localparam logic [CNT_IDX_W-1:0] OFS_REQUESTS  = 4'd1;
    localparam logic [CNT_IDX_W-1:0] OFS_SEEK_DIST = 4'd2;
    localparam logic [CNT_IDX_W-1:0] OFS_SEEKS     = 4'd3;

    typedef struct packed {
        logic [1:0]           req_type;
        logic                 is_write;
        logic [SECTOR_W-1:0]  start_sector;
        logic [COUNT_W-1:0]   sector_count;
        logic [1:0]           outcome;
        logic [CNT_IDX_W-1:0] counter_index;
    } req_t;

endpackage

// ===== rtl/core/bio_req_if.sv =====
// ----------------------------------------------------------------------------
// Block I/O statistics request channel
// Valid/ready channel carrying one event per transfer.
// ----------------------------------------------------------------------------
interface bio_req_if;

    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic        is_write;
    logic [63:0] start_sector;
    logic [31:0] sector_count;
    logic [1:0]  outcome;
    logic [3:0]  counter_index;

    modport source
    (
        output valid,
        input  ready,
        output req_type,
        output is_write,
        output start_sector,
        output sector_count,
        output outcome,
        output counter_index
    );

    modport sink
    (
        input  valid,
        output ready,
        input  req_type,
        input  is_write,
        input  start_sector,
        input  sector_count,
        input  outcome,
        input  counter_index
    );

endinterface

// ===== rtl/core/bio_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Block I/O statistics response channel
// Valid/ready channel carrying one counter value per transfer.
// ----------------------------------------------------------------------------
interface bio_rsp_if;

    logic        valid;
    logic        ready;
    logic [63:0] counter_value;

    modport source
    (
        output valid,
        input  ready,
        output counter_value
    );

    modport sink
    (
        input  valid,
        output ready,
        input  counter_value
    );

endinterface

// ===== rtl/core/block_io_statistics_counter.sv =====
// ----------------------------------------------------------------------------
// Block I/O statistics counter
// Per-direction issue, seek and completion counters with indexed readback.
// ----------------------------------------------------------------------------
// Throughput: one event per cycle, while a read is not held by an untaken earlier result.
// Read path: a counter read passes through the input register, then the result
//   register; a read waits in the input register while an earlier result is not
//   yet taken.
// Reset: asynchronous, clears all counters, the expected sector and the
//   last direction at once; no clearing pass.
`include "block_io_statistics_counter_macros.svh"

module block_io_statistics_counter
#(
    parameter int COUNTER_WIDTH = bio_pkg::CNT_WIDTH_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    bio_req_if.sink         req,
    bio_rsp_if.source       rsp
);

    bio_pkg::req_t                    in_reg;
    logic                             in_valid_reg;
    logic                             in_valid_next;
    logic                             accept;
    logic                             proceed;
    logic                             is_read;

    logic [COUNTER_WIDTH-1:0]         cnt_reg  [bio_pkg::NUM_COUNTERS];
    logic [COUNTER_WIDTH-1:0]         cnt_next [bio_pkg::NUM_COUNTERS];
    logic [bio_pkg::SECTOR_W-1:0]     exp_reg;
    logic [bio_pkg::SECTOR_W-1:0]     exp_next;
    bio_pkg::dir_t                    dir_reg;
    bio_pkg::dir_t                    dir_next;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [63:0]                      out_value_reg;
    logic [63:0]                      rd_value;

    bio_pkg::dir_t                    dir_in;
    logic [bio_pkg::CNT_IDX_W-1:0]    grp;
    logic [bio_pkg::CNT_IDX_W-1:0]    cpl;
    logic [bio_pkg::CNT_IDX_W-1:0]    idx_sect;
    logic [bio_pkg::CNT_IDX_W-1:0]    idx_reqs;
    logic [bio_pkg::CNT_IDX_W-1:0]    idx_dist;
    logic [bio_pkg::CNT_IDX_W-1:0]    idx_seeks;
    logic [bio_pkg::CNT_IDX_W-1:0]    idx_cpl_reqs;
    logic                             seq;
    logic [bio_pkg::SECTOR_W-1:0]     seek_len;
    logic [COUNTER_WIDTH-1:0]         count_w;
    logic [COUNTER_WIDTH-1:0]         dist_w;
    logic [COUNTER_WIDTH-1:0]         one_w;

    assign is_read   = (bio_pkg::req_kind_t'(in_reg.req_type) == bio_pkg::REQ_READ);
    assign proceed   = in_valid_reg && (!is_read || !out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || proceed;
    assign accept    = req.valid && req.ready;

    assign in_valid_next = accept ? 1'b1 : (proceed ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg.req_type      <= req.req_type;
            in_reg.is_write      <= req.is_write;
            in_reg.start_sector  <= req.start_sector;
            in_reg.sector_count  <= req.sector_count;
            in_reg.outcome       <= req.outcome;
            in_reg.counter_index <= req.counter_index;
        end
    end

    assign dir_in       = in_reg.is_write ? bio_pkg::DIR_WRITE : bio_pkg::DIR_READ;
    assign grp          = in_reg.is_write ? bio_pkg::IDX_WR_ISSUE : bio_pkg::IDX_RD_ISSUE;
    assign cpl          = in_reg.is_write ? bio_pkg::IDX_CPL_WR : bio_pkg::IDX_CPL_RD;
    assign idx_sect     = grp + bio_pkg::OFS_SECTORS;
    assign idx_reqs     = grp + bio_pkg::OFS_REQUESTS;
    assign idx_dist     = grp + bio_pkg::OFS_SEEK_DIST;
    assign idx_seeks    = grp + bio_pkg::OFS_SEEKS;
    assign idx_cpl_reqs = cpl + bio_pkg::OFS_REQUESTS;

    assign seq  = ((in_reg.start_sector == exp_reg) && (dir_reg == dir_in))
                  || (dir_reg == bio_pkg::DIR_NONE);
    assign seek_len = (in_reg.start_sector > exp_reg) ? (in_reg.start_sector - exp_reg)
                                                      : (exp_reg - in_reg.start_sector);

    assign count_w = COUNTER_WIDTH'(in_reg.sector_count);
    assign dist_w  = COUNTER_WIDTH'(seek_len);
    assign one_w   = COUNTER_WIDTH'(1'b1);

    always_comb
    begin
        cnt_next = cnt_reg;
        exp_next = exp_reg;
        dir_next = dir_reg;
        if (proceed)
        begin
            unique case (bio_pkg::req_kind_t'(in_reg.req_type))
                bio_pkg::REQ_ISSUE:
                begin
                    cnt_next[idx_sect] = cnt_reg[idx_sect] + count_w;
                    cnt_next[idx_reqs] = cnt_reg[idx_reqs] + one_w;
                    if (!seq)
                    begin
                        cnt_next[idx_dist]  = cnt_reg[idx_dist] + dist_w;
                        cnt_next[idx_seeks] = cnt_reg[idx_seeks] + one_w;
                    end
                    dir_next = dir_in;
                    exp_next = in_reg.start_sector
                               + bio_pkg::SECTOR_W'(in_reg.sector_count);
                end
                bio_pkg::REQ_COMPLETE:
                begin
                    if (bio_pkg::outcome_t'(in_reg.outcome) == bio_pkg::OUTCOME_SUCCESS)
                    begin
                        cnt_next[cpl]          = cnt_reg[cpl] + count_w;
                        cnt_next[idx_cpl_reqs] = cnt_reg[idx_cpl_reqs] + one_w;
                    end
                    else if (bio_pkg::outcome_t'(in_reg.outcome) != bio_pkg::OUTCOME_RETRY)
                    begin
                        cnt_next[bio_pkg::IDX_FAILED] = cnt_reg[bio_pkg::IDX_FAILED] + one_w;
                    end
                end
                bio_pkg::REQ_READ:
                begin
                    exp_next = exp_reg;
                end
                bio_pkg::REQ_CLEAR:
                begin
                    for (int i = 0; i < bio_pkg::NUM_COUNTERS; i++)
                    begin
                        cnt_next[i] = '0;
                    end
                    exp_next = '0;
                    dir_next = bio_pkg::DIR_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bio_pkg::NUM_COUNTERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            exp_reg <= '0;
            dir_reg <= bio_pkg::DIR_NONE;
        end
        else
        begin
            cnt_reg <= cnt_next;
            exp_reg <= exp_next;
            dir_reg <= dir_next;
        end
    end

    assign rd_value = (in_reg.counter_index < bio_pkg::CNT_IDX_W'(bio_pkg::NUM_COUNTERS))
                      ? 64'(cnt_reg[in_reg.counter_index]) : '0;

    assign out_valid_next = (proceed && is_read) ? 1'b1
                          : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result until its transfer
    always_ff @(posedge clk)
    begin
        if (proceed && is_read)
        begin
            out_value_reg <= rd_value;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.counter_value = out_value_reg;

    `BIO_ASSERT(a_in_hold, clk, rst_n,
        (in_valid_reg && !proceed) |=> (in_valid_reg && $stable(in_reg)),
        "pending event lost or altered")
    `BIO_ASSERT(a_read_result, clk, rst_n,
        (proceed && is_read) |=> out_valid_reg,
        "counter read gave no result")
    `BIO_ASSERT(a_clear_state, clk, rst_n,
        (proceed && bio_pkg::req_kind_t'(in_reg.req_type) == bio_pkg::REQ_CLEAR)
            |=> (dir_reg == bio_pkg::DIR_NONE && exp_reg == '0),
        "clear left state behind")
    `BIO_ASSERT(a_issue_dir, clk, rst_n,
        (proceed && bio_pkg::req_kind_t'(in_reg.req_type) == bio_pkg::REQ_ISSUE)
            |=> (dir_reg != bio_pkg::DIR_NONE),
        "issue did not record direction")
    `BIO_ASSERT_NEVER(a_no_overrun, clk, rst_n,
        proceed && is_read && out_valid_reg && !rsp.ready,
        "result register overwritten")

endmodule

// ===== tb/bio_stats_checker.sv =====
// ----------------------------------------------------------------------------
// Block I/O statistics counter - checker
// Watches the request and response channels and keeps its own copy of the
// issue, seek and completion counters. It predicts the value of every counter
// read and compares each response transfer with the oldest pending value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bio_stats_checker
#(
    parameter int COUNTER_WIDTH = bio_pkg::CNT_WIDTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    bio_req_if   req,
    bio_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding
);

    import bio_pkg::*;

    localparam logic [63:0] CNT_MASK =
        (COUNTER_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << COUNTER_WIDTH) - 64'd1);

    logic [63:0] tally [NUM_COUNTERS];
    logic [63:0] end_sector;
    dir_t        last_dir;
    logic [63:0] pending_values [$];
    int          errors = 0;
    int          depth  = 0;

    assign mismatches  = errors;
    assign outstanding = depth;

    function automatic logic [63:0] bump(input logic [63:0] a, input logic [63:0] b);
        return (a + b) & CNT_MASK;
    endfunction

    function automatic void clear_stats();
        for (int i = 0; i < NUM_COUNTERS; i++)
        begin
            tally[i] = '0;
        end
        end_sector = '0;
        last_dir   = DIR_NONE;
    endfunction

    function automatic void account(input req_t ev);
        logic [CNT_IDX_W-1:0] base;
        logic [63:0]          count;
        logic [63:0]          seek_len;
        logic                 in_order;
        dir_t                 dir;
        count = {32'd0, ev.sector_count};
        dir   = ev.is_write ? DIR_WRITE : DIR_READ;
        case (req_kind_t'(ev.req_type))
            REQ_ISSUE:
            begin
                base     = ev.is_write ? IDX_WR_ISSUE : IDX_RD_ISSUE;
                in_order = (last_dir == DIR_NONE)
                           || (ev.start_sector == end_sector && dir == last_dir);
                tally[base + OFS_SECTORS]  = bump(tally[base + OFS_SECTORS], count);
                tally[base + OFS_REQUESTS] = bump(tally[base + OFS_REQUESTS], 64'd1);
                if (!in_order)
                begin
                    seek_len = (ev.start_sector > end_sector) ? ev.start_sector - end_sector
                                                              : end_sector - ev.start_sector;
                    tally[base + OFS_SEEK_DIST] = bump(tally[base + OFS_SEEK_DIST], seek_len);
                    tally[base + OFS_SEEKS]     = bump(tally[base + OFS_SEEKS], 64'd1);
                end
                last_dir   = dir;
                end_sector = ev.start_sector + count;
            end
            REQ_COMPLETE:
            begin
                base = ev.is_write ? IDX_CPL_WR : IDX_CPL_RD;
                if (ev.outcome == OUTCOME_SUCCESS)
                begin
                    tally[base + OFS_SECTORS]  = bump(tally[base + OFS_SECTORS], count);
                    tally[base + OFS_REQUESTS] = bump(tally[base + OFS_REQUESTS], 64'd1);
                end
                else if (ev.outcome != OUTCOME_RETRY)
                begin
                    tally[IDX_FAILED] = bump(tally[IDX_FAILED], 64'd1);
                end
            end
            REQ_READ:
            begin
                if (ev.counter_index < NUM_COUNTERS)
                begin
                    pending_values.push_back(tally[ev.counter_index]);
                end
                else
                begin
                    pending_values.push_back(64'd0);
                end
            end
            default:
            begin
                clear_stats();
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        req_t        ev;
        logic [63:0] want;
        if (!rst_n)
        begin
            clear_stats();
            pending_values.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_values.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("%0t: unexpected counter_value %h", $realtime,
                                 rsp.counter_value);
                    end
                end
                else
                begin
                    want = pending_values.pop_front();
                    if (rsp.counter_value !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: counter_value expected %h actual %h", $realtime,
                                     want, rsp.counter_value);
                        end
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                ev.req_type      = req.req_type;
                ev.is_write      = req.is_write;
                ev.start_sector  = req.start_sector;
                ev.sector_count  = req.sector_count;
                ev.outcome       = req.outcome;
                ev.counter_index = req.counter_index;
                account(ev);
            end
        end
        depth = pending_values.size();
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Block I/O statistics counter - testbench top
// Drives a directed run over the counter extremes, seek distance wrap, every
// completion outcome and every counter index, then a long random run built
// mostly from sequential request streams. Both channels stall at random; the
// checker beside the block predicts and compares every counter read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import bio_pkg::*;

    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam int          RANDOM_EVENTS   = 1350;
    localparam int          DRAIN_INTERVAL  = 300;
    localparam logic [1:0]  OUTCOME_UNKNOWN = 2'd3;
    localparam logic [63:0] SECTOR_MAX      = {64{1'b1}};
    localparam logic [31:0] COUNT_MAX       = {32{1'b1}};

    logic        clk;
    logic        rst_n;
    int          mismatches;
    int          outstanding;
    int          quiet;
    logic        snd_calm;
    logic        rcv_calm;
    logic [63:0] head;

    bio_req_if req_ch ();
    bio_rsp_if rsp_ch ();

    block_io_statistics_counter dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bio_stats_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic transfer(input req_kind_t kind, input logic wr, input logic [63:0] start,
                            input logic [31:0] count, input logic [1:0] outc,
                            input logic [3:0] idx);
        int gap;
        if ($urandom_range(0, 15) == 0)
        begin
            snd_calm = ~snd_calm;
        end
        gap = snd_calm ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= kind;
        req_ch.is_write      <= wr;
        req_ch.start_sector  <= start;
        req_ch.sector_count  <= count;
        req_ch.outcome       <= outc;
        req_ch.counter_index <= idx;
        if (kind == REQ_ISSUE)
        begin
            head = start + {32'd0, count};
        end
        else if (kind == REQ_CLEAR)
        begin
            head = '0;
        end
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // hold the request channel idle until every pending read has returned
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        rcv_calm     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                rcv_calm = ~rcv_calm;
            end
            stall = rcv_calm ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet <= 0;
        end
        else if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    initial
    begin
        int          pick;
        int          sel;
        req_kind_t   kind;
        logic        wr;
        logic [63:0] start;
        logic [31:0] count;
        logic [1:0]  outc;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_ISSUE;
        req_ch.is_write      = 1'b0;
        req_ch.start_sector  = '0;
        req_ch.sector_count  = '0;
        req_ch.outcome       = OUTCOME_SUCCESS;
        req_ch.counter_index = '0;
        rst_n                = 1'b0;
        snd_calm             = 1'b0;
        head                 = '0;
        wr                   = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first issue after reset counts as sequential; its end sector wraps
        transfer(REQ_ISSUE, 1'b0, SECTOR_MAX, COUNT_MAX, OUTCOME_SUCCESS, IDX_RD_ISSUE);
        transfer(REQ_ISSUE, 1'b0, head, 32'd1, OUTCOME_SUCCESS, IDX_RD_ISSUE);
        // direction change: seek of zero distance, then seeks up to the full range
        transfer(REQ_ISSUE, 1'b1, head, 32'd0, OUTCOME_SUCCESS, IDX_WR_ISSUE);
        transfer(REQ_ISSUE, 1'b1, 64'd0, 32'd5, OUTCOME_SUCCESS, IDX_WR_ISSUE);
        transfer(REQ_ISSUE, 1'b1, SECTOR_MAX, 32'd0, OUTCOME_SUCCESS, IDX_WR_ISSUE);
        transfer(REQ_ISSUE, 1'b1, 64'd0, 32'd0, OUTCOME_SUCCESS, IDX_WR_ISSUE);
        transfer(REQ_COMPLETE, 1'b0, 64'd0, COUNT_MAX, OUTCOME_SUCCESS, IDX_CPL_RD);
        transfer(REQ_COMPLETE, 1'b1, SECTOR_MAX, 32'd7, OUTCOME_SUCCESS, IDX_CPL_WR);
        transfer(REQ_COMPLETE, 1'b1, 64'd3, 32'd9, OUTCOME_RETRY, IDX_CPL_WR);
        transfer(REQ_COMPLETE, 1'b0, 64'd4, 32'd2, OUTCOME_ERROR, IDX_FAILED);
        transfer(REQ_COMPLETE, 1'b0, 64'd5, 32'd2, OUTCOME_UNKNOWN, IDX_FAILED);
        for (int i = 0; i < 16; i++)
        begin
            transfer(REQ_READ, i[0], SECTOR_MAX, COUNT_MAX, OUTCOME_UNKNOWN, 4'(i));
        end
        transfer(REQ_CLEAR, 1'b1, SECTOR_MAX, COUNT_MAX, OUTCOME_UNKNOWN, IDX_FAILED);
        transfer(REQ_ISSUE, 1'b1, 64'h1234_5678_9abc_def0, 32'd8, OUTCOME_SUCCESS, IDX_FAILED);
        transfer(REQ_READ, 1'b0, 64'd0, 32'd0, OUTCOME_SUCCESS, IDX_WR_ISSUE + OFS_SEEKS);
        transfer(REQ_READ, 1'b0, 64'd0, 32'd0, OUTCOME_SUCCESS, IDX_FAILED);
        drain();

        for (int n = 0; n < RANDOM_EVENTS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 48)
            begin
                kind = REQ_ISSUE;
            end
            else if (pick < 72)
            begin
                kind = REQ_COMPLETE;
            end
            else if (pick < 99)
            begin
                kind = REQ_READ;
            end
            else
            begin
                kind = REQ_CLEAR;
            end
            if ($urandom_range(0, 4) == 0)
            begin
                wr = ~wr;
            end
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                count = $urandom;
            end
            else if (sel == 1)
            begin
                count = COUNT_MAX;
            end
            else if (sel == 2)
            begin
                count = '0;
            end
            else
            begin
                count = $urandom_range(1, 256);
            end
            sel = $urandom_range(0, 9);
            if (sel < 6)
            begin
                start = head;
            end
            else if (sel == 6)
            begin
                start = head + 64'($urandom_range(1, 64));
            end
            else if (sel == 7)
            begin
                start = head - 64'($urandom_range(1, 64));
            end
            else
            begin
                start = {$urandom, $urandom};
            end
            outc = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : OUTCOME_SUCCESS;
            transfer(kind, wr, start, count, outc, 4'($urandom_range(0, 15)));
            if (n % DRAIN_INTERVAL == DRAIN_INTERVAL - 1)
            begin
                drain();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
